FILE: rtl/dbc_pkg.sv
// ----------------------------------------------------------------------------
// dbc_pkg
// Shared types and constants for the delimiter balance checker.
// ----------------------------------------------------------------------------
package dbc_pkg;

  localparam int unsigned LineW = 20;
  localparam int unsigned ColW  = 16;
  localparam int unsigned MaxRes = 3;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QAddrW = 2;

  localparam logic [LineW-1:0] LineMax = '1;
  localparam logic [ColW-1:0]  ColMax  = '1;

  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChQuote   = 8'h22;
  localparam logic [7:0] ChBslash  = 8'h5C;
  localparam logic [7:0] ChParenO  = 8'h28;
  localparam logic [7:0] ChParenC  = 8'h29;
  localparam logic [7:0] ChSquareO = 8'h5B;
  localparam logic [7:0] ChSquareC = 8'h5D;
  localparam logic [7:0] ChBraceO  = 8'h7B;
  localparam logic [7:0] ChBraceC  = 8'h7D;

  typedef logic [1:0] delim_t;
  localparam delim_t DelimParen  = 2'd0;
  localparam delim_t DelimSquare = 2'd1;
  localparam delim_t DelimBrace  = 2'd2;

  typedef enum logic [1:0] {
    STK_HOLD,
    STK_PUSH,
    STK_POP
  } stk_op_e;

  typedef enum logic [2:0] {
    DIAG_UNMATCHED    = 3'd0,
    DIAG_MISMATCH     = 3'd1,
    DIAG_UNTERMINATED = 3'd2,
    DIAG_UNCLOSED     = 3'd3,
    DIAG_OVERFLOW     = 3'd4,
    DIAG_DONE         = 3'd5
  } diag_code_e;

  typedef struct packed {
    logic [LineW-1:0] line;
    logic [ColW-1:0]  column;
    diag_code_e       code;
    logic             last;
  } diag_t;

  typedef struct packed {
    logic [1:0]         n;
    diag_t [MaxRes-1:0] item;
  } rq_wr_t;

endpackage

FILE: rtl/dbc_cell.sv
// ----------------------------------------------------------------------------
// dbc_cell
// One delimiter stack slot; shifts down on push, up on pop.
// ----------------------------------------------------------------------------
module dbc_cell
  import dbc_pkg::*;
(
  input  logic    clk_i,
  input  stk_op_e op_i,
  input  delim_t  above_i,
  input  delim_t  below_i,
  output delim_t  q_o
);

  delim_t val_q;

  always_ff @(posedge clk_i) begin
    case (op_i)
      STK_PUSH: val_q <= above_i;
      STK_POP:  val_q <= below_i;
      default:  val_q <= val_q;
    endcase
  end

  assign q_o = val_q;

endmodule

FILE: rtl/dbc_outq.sv
// ----------------------------------------------------------------------------
// dbc_outq
// Result queue; takes up to three results per cycle, gives one per cycle while ready_i is high.
// ----------------------------------------------------------------------------
module dbc_outq
  import dbc_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  rq_wr_t wr_i,
  output logic   space_o,
  output logic   valid_o,
  input  logic   ready_i,
  output diag_t  data_o
);

  diag_t             mem_q [QDepth];
  logic [QAddrW-1:0] head_q, head_d, tail_q, tail_d;
  logic [QAddrW:0]   cnt_q, cnt_d;
  logic              pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != '0);
  assign space_o = (cnt_q <= (QAddrW+1)'(QDepth - MaxRes));
  assign data_o  = mem_q[head_q];

  always_comb begin
    head_d = head_q + QAddrW'(pop);
    tail_d = tail_q + QAddrW'(wr_i.n);
    cnt_d  = cnt_q + (QAddrW+1)'(wr_i.n) - (QAddrW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MaxRes; k++) begin
      if (2'(k) < wr_i.n) begin
        mem_q[tail_q + QAddrW'(k)] <= wr_i.item[k];
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (QAddrW+1)'(QDepth))
    else $error("result queue overrun");
`endif

endmodule

FILE: rtl/delimiter_balance_checker.sv
// Results: a request's results are registered in the result queue and reach the master side in order.
// Throughput: one request per cycle while each request yields at most one result and
// m_axis_tready_i stays high; tready drops while the four-slot queue holds two or more.
// Stack: a chain of STACK_DEPTH shift cells, top in cell 0, one push or pop per cycle.
// Reset: asynchronous, active low; sets line and column to 1, clears modes, stack count and queue pointers.
// ----------------------------------------------------------------------------
// delimiter_balance_checker
// Bracket balance check over a byte stream with line and column tracking.
// ----------------------------------------------------------------------------
module delimiter_balance_checker
  import dbc_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] text_byte
  input  logic        s_axis_tuser_i,   // [0] has_byte
  input  logic        s_axis_tlast_i,   // doc_end
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [19:0] diag_line, [35:20] diag_column, zero pad
  output logic [2:0]  m_axis_tuser_o,   // [2:0] diag_code
  output logic        m_axis_tlast_o    // run_last
);

  localparam int unsigned CntW = $clog2(STACK_DEPTH + 1);

  logic [LineW-1:0] line_q, line_d;
  logic [ColW-1:0]  col_q, col_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             str_q, str_d, bs_q, bs_d;

  logic       acc;
  logic       is_open, is_close;
  delim_t     open_code, close_code, top;
  stk_op_e    op;
  rq_wr_t     wr;
  diag_t      head;
  delim_t     cell_q [STACK_DEPTH];

  assign acc = s_axis_tvalid_i && s_axis_tready_o;
  assign top = cell_q[0];

  always_comb begin
    is_open    = 1'b0;
    is_close   = 1'b0;
    open_code  = DelimParen;
    close_code = DelimParen;
    case (s_axis_tdata_i)
      ChParenO:  begin is_open = 1'b1;  open_code = DelimParen;   end
      ChSquareO: begin is_open = 1'b1;  open_code = DelimSquare;  end
      ChBraceO:  begin is_open = 1'b1;  open_code = DelimBrace;   end
      ChParenC:  begin is_close = 1'b1; close_code = DelimParen;  end
      ChSquareC: begin is_close = 1'b1; close_code = DelimSquare; end
      ChBraceC:  begin is_close = 1'b1; close_code = DelimBrace;  end
      default:   begin is_open = 1'b0; end
    endcase
  end

  always_comb begin
    line_d = line_q;
    col_d  = col_q;
    cnt_d  = cnt_q;
    str_d  = str_q;
    bs_d   = bs_q;
    op     = STK_HOLD;
    wr     = '0;
    if (acc) begin
      if (s_axis_tuser_i) begin
        bs_d = (s_axis_tdata_i == ChBslash);
        if (s_axis_tdata_i == ChNewline) begin
          if (line_q != LineMax) line_d = line_q + 1'b1;
          col_d = ColW'(1);
        end else begin
          if (s_axis_tdata_i == ChQuote && !bs_q) begin
            str_d = !str_q;
          end else if (!str_q) begin
            if (is_open) begin
              if (cnt_q < CntW'(STACK_DEPTH)) begin
                op    = STK_PUSH;
                cnt_d = cnt_q + 1'b1;
              end else begin
                wr.item[0] = '{line_q, col_q, DIAG_OVERFLOW, 1'b0};
                wr.n       = 2'd1;
              end
            end else if (is_close) begin
              if (cnt_q == '0) begin
                wr.item[0] = '{line_q, col_q, DIAG_UNMATCHED, 1'b0};
                wr.n       = 2'd1;
              end else if (top != close_code) begin
                wr.item[0] = '{line_q, col_q, DIAG_MISMATCH, 1'b0};
                wr.n       = 2'd1;
              end else begin
                op    = STK_POP;
                cnt_d = cnt_q - 1'b1;
              end
            end
          end
          if (col_q != ColMax) col_d = col_q + 1'b1;
        end
      end
      if (s_axis_tlast_i) begin
        if (str_d) begin
          wr.item[wr.n] = '{line_d, col_d, DIAG_UNTERMINATED, 1'b0};
          wr.n          = wr.n + 1'b1;
        end
        if (cnt_d != '0) begin
          wr.item[wr.n] = '{line_d, col_d, DIAG_UNCLOSED, 1'b0};
          wr.n          = wr.n + 1'b1;
        end
        if (!str_d && cnt_d == '0) begin
          wr.item[wr.n] = '{line_d, col_d, DIAG_DONE, 1'b0};
          wr.n          = wr.n + 1'b1;
        end
        line_d = LineW'(1);
        col_d  = ColW'(1);
        cnt_d  = '0;
        str_d  = 1'b0;
        bs_d   = 1'b0;
      end
      if (wr.n != 2'd0) wr.item[wr.n - 2'd1].last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q <= LineW'(1);
      col_q  <= ColW'(1);
      cnt_q  <= '0;
      str_q  <= 1'b0;
      bs_q   <= 1'b0;
    end else begin
      line_q <= line_d;
      col_q  <= col_d;
      cnt_q  <= cnt_d;
      str_q  <= str_d;
      bs_q   <= bs_d;
    end
  end

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    delim_t above, below;
    if (i == 0) begin : g_top
      assign above = open_code;
    end else begin : g_mid
      assign above = cell_q[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_bot
      assign below = cell_q[i];
    end else begin : g_up
      assign below = cell_q[i+1];
    end
    dbc_cell u_cell (
      .clk_i   (clk_i),
      .op_i    (op),
      .above_i (above),
      .below_i (below),
      .q_o     (cell_q[i])
    );
  end

  dbc_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (wr),
    .space_o (s_axis_tready_o),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .data_o  (head)
  );

  assign m_axis_tdata_o = {4'b0, head.column, head.line};
  assign m_axis_tuser_o = head.code;
  assign m_axis_tlast_o = head.last;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(STACK_DEPTH))
    else $error("stack count beyond depth");
  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && s_axis_tlast_i |=> cnt_q == '0 && !str_q && !bs_q)
    else $error("document end left state behind");
  a_end_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && s_axis_tlast_i |=> m_axis_tvalid_o)
    else $error("document end gave no result");
`endif

endmodule

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Checks the delimiter balance checker against its own predictor of the
// bracket stack, string mode and line/column counters. A short table of
// requests covers reset, escapes, mismatches and document end. Random
// documents and a nesting-overflow burst follow. Both stream sides stall
// at random in the first two of three phases.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dbc_pkg::*;

  localparam int unsigned NestDepth = 64;

  localparam logic [7:0] OpenCh  [3] = '{ChParenO, ChSquareO, ChBraceO};
  localparam logic [7:0] CloseCh [3] = '{ChParenC, ChSquareC, ChBraceC};

  typedef struct packed {
    logic [7:0]       text_byte;
    logic             has_byte;
    logic             doc_end;
    logic             fixed;
    diag_code_e       code;
    logic [LineW-1:0] line;
    logic [ColW-1:0]  column;
  } text_req_t;

  // fixed rows carry the single result that the request must produce
  localparam int unsigned NumDirected = 26;
  localparam text_req_t DirectedReqs [NumDirected] = '{
    '{8'h00,     1'b0, 1'b1, 1'b1, DIAG_DONE,         20'd1, 16'd1},
    '{ChParenC,  1'b1, 1'b0, 1'b1, DIAG_UNMATCHED,    20'd1, 16'd1},
    '{ChParenO,  1'b1, 1'b0, 1'b0, DIAG_DONE,         20'd0, 16'd0},
    '{ChSquareC, 1'b1, 1'b0, 1'b1, DIAG_MISMATCH,     20'd1, 16'd3},
    '{ChParenC,  1'b1, 1'b0, 1'b0, DIAG_DONE,         20'd0, 16'd0},
    '{ChQuote,   1'b1, 1'b0, 1'b0, DIAG_DONE,         20'd0, 16'd0},
    '{ChBslash,  1'b1, 1'b0, 1'b0, DIAG_DONE,         20'd0, 16'd0},
    '{ChQuote,   1'b1, 1'b0, 1'b0, DIAG_DONE,         20'd0, 16'd0},
    '{ChBraceC,  1'b1, 1'b0, 1'b0, DIAG_DONE,         20'd0, 16'd0},
    '{ChQuote,   1'b1, 1'b0, 1'b0, DIAG_DONE,         20'd0, 16'd0},
    '{8'hFF,     1'b1, 1'b0, 1'b0, DIAG_DONE,         20'd0, 16'd0},
    '{8'h00,     1'b1, 1'b0, 1'b0, DIAG_DONE,         20'd0, 16'd0},
    '{ChNewline, 1'b1, 1'b0, 1'b0, DIAG_DONE,         20'd0, 16'd0},
    '{ChBraceO,  1'b1, 1'b0, 1'b0, DIAG_DONE,         20'd0, 16'd0},
    '{ChSquareO, 1'b1, 1'b0, 1'b0, DIAG_DONE,         20'd0, 16'd0},
    '{ChSquareC, 1'b0, 1'b0, 1'b0, DIAG_DONE,         20'd0, 16'd0},
    '{ChBraceC,  1'b1, 1'b0, 1'b1, DIAG_MISMATCH,     20'd2, 16'd3},
    '{ChSquareC, 1'b1, 1'b0, 1'b0, DIAG_DONE,         20'd0, 16'd0},
    '{ChBslash,  1'b1, 1'b0, 1'b0, DIAG_DONE,         20'd0, 16'd0},
    '{ChQuote,   1'b1, 1'b0, 1'b0, DIAG_DONE,         20'd0, 16'd0},
    '{ChQuote,   1'b1, 1'b1, 1'b0, DIAG_DONE,         20'd0, 16'd0},
    '{8'hA5,     1'b0, 1'b1, 1'b1, DIAG_DONE,         20'd1, 16'd1},
    '{ChParenO,  1'b1, 1'b1, 1'b1, DIAG_UNCLOSED,     20'd1, 16'd2},
    '{ChBslash,  1'b1, 1'b0, 1'b0, DIAG_DONE,         20'd0, 16'd0},
    '{ChNewline, 1'b1, 1'b0, 1'b0, DIAG_DONE,         20'd0, 16'd0},
    '{ChQuote,   1'b1, 1'b1, 1'b1, DIAG_UNTERMINATED, 20'd2, 16'd2}
  };

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = 8'h00;  // [7:0] text_byte
  logic        s_axis_tuser_i = 1'b0;   // [0] has_byte
  logic        s_axis_tlast_i = 1'b0;   // doc_end
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [39:0] m_axis_tdata_o;          // [19:0] diag_line, [35:20] diag_column, zero pad
  logic [2:0]  m_axis_tuser_o;          // [2:0] diag_code
  logic        m_axis_tlast_o;          // run_last

  delimiter_balance_checker #(
    .STACK_DEPTH(NestDepth)
  ) dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .s_axis_tuser_i,
    .s_axis_tlast_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o,
    .m_axis_tuser_o,
    .m_axis_tlast_o
  );

  // predictor state
  delim_t           nest_stack [NestDepth];
  int unsigned      nest_depth;
  bit               in_str;
  bit               after_bs;
  logic [LineW-1:0] pred_line;
  logic [ColW-1:0]  cur_col;

  diag_t       step_diags [$];
  diag_t       pending_diags [$];
  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  int unsigned fails;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #15ms;
    $display("Test completed with failures");
    $finish;
  end

  always @(negedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk_i) begin
    diag_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_diags.size() == 0) begin
        $error("unexpected result: line %0d column %0d code %0d",
               m_axis_tdata_o[19:0], m_axis_tdata_o[35:20], m_axis_tuser_o);
        fails++;
      end else begin
        want = pending_diags.pop_front();
        if (m_axis_tdata_o[19:0] != want.line) begin
          $error("diag_line expected %0d actual %0d", want.line, m_axis_tdata_o[19:0]);
          fails++;
        end
        if (m_axis_tdata_o[35:20] != want.column) begin
          $error("diag_column expected %0d actual %0d", want.column, m_axis_tdata_o[35:20]);
          fails++;
        end
        if (m_axis_tuser_o != want.code) begin
          $error("diag_code expected %0d actual %0d", want.code, m_axis_tuser_o);
          fails++;
        end
        if (m_axis_tlast_o != want.last) begin
          $error("run_last expected %0d actual %0d", want.last, m_axis_tlast_o);
          fails++;
        end
        if (m_axis_tdata_o[39:36] != 4'h0) begin
          $error("tdata pad expected 0 actual %0h", m_axis_tdata_o[39:36]);
          fails++;
        end
      end
    end
  end

  function automatic void clear_doc();
    nest_depth = 0;
    in_str     = 1'b0;
    after_bs   = 1'b0;
    pred_line  = LineW'(1);
    cur_col    = ColW'(1);
  endfunction

  function automatic diag_t diag_here(diag_code_e c);
    return '{line: pred_line, column: cur_col, code: c, last: 1'b0};
  endfunction

  function automatic void note_diag(diag_code_e c);
    step_diags = {step_diags, diag_here(c)};
  endfunction

  // diagnostics caused by one request, left in step_diags
  function automatic void predict_diags(logic [7:0] b, logic h, logic e);
    bit          was_bs;
    int unsigned opn;
    int unsigned cls;
    int unsigned base;
    step_diags.delete();
    if (h) begin
      was_bs   = after_bs;
      after_bs = (b == ChBslash);
      if (b == ChNewline) begin
        if (pred_line != LineMax) pred_line++;
        cur_col = ColW'(1);
      end else begin
        opn = 3;
        cls = 3;
        for (int k = 0; k < 3; k++) begin
          if (b == OpenCh[k]) opn = k;
          if (b == CloseCh[k]) cls = k;
        end
        if (b == ChQuote && !was_bs) begin
          in_str = !in_str;
        end else if (!in_str) begin
          if (opn < 3) begin
            if (nest_depth < NestDepth) begin
              nest_stack[nest_depth] = delim_t'(opn);
              nest_depth++;
            end else begin
              note_diag(DIAG_OVERFLOW);
            end
          end else if (cls < 3) begin
            if (nest_depth == 0) begin
              note_diag(DIAG_UNMATCHED);
            end else if (nest_stack[nest_depth-1] != delim_t'(cls)) begin
              note_diag(DIAG_MISMATCH);
            end else begin
              nest_depth--;
            end
          end
        end
        if (cur_col != ColMax) cur_col++;
      end
    end
    if (e) begin
      base = step_diags.size();
      if (in_str) note_diag(DIAG_UNTERMINATED);
      if (nest_depth != 0) note_diag(DIAG_UNCLOSED);
      if (step_diags.size() == base) note_diag(DIAG_DONE);
      clear_doc();
    end
    if (step_diags.size() != 0) step_diags[step_diags.size()-1].last = 1'b1;
  endfunction

  task automatic send_req(text_req_t r);
    diag_t fixed_diag;
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= r.text_byte;
    s_axis_tuser_i  <= r.has_byte;
    s_axis_tlast_i  <= r.doc_end;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    predict_diags(r.text_byte, r.has_byte, r.doc_end);
    if (r.fixed) begin
      fixed_diag = '{line: r.line, column: r.column, code: r.code, last: 1'b1};
      pending_diags = {pending_diags, fixed_diag};
    end else begin
      pending_diags = {pending_diags, step_diags};
    end
  endtask

  function automatic text_req_t byte_req(logic [7:0] b, logic e);
    text_req_t r;
    r           = '0;
    r.text_byte = b;
    r.has_byte  = 1'b1;
    r.doc_end   = e;
    return r;
  endfunction

  // sender holds off until every result is back
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (pending_diags.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic random_text(int unsigned count);
    text_req_t   r;
    int unsigned sent;
    int unsigned pick;
    sent = 0;
    while (sent < count) begin
      r    = byte_req(8'($urandom_range(255)), 1'b0);
      pick = $urandom_range(99);
      if (pick < 4) begin
        r.has_byte = 1'b0;
      end else if (pick < 10) begin
        r.has_byte = 1'($urandom_range(1));
        r.doc_end  = 1'b1;
      end else if (pick < 30) begin
        r.text_byte = OpenCh[$urandom_range(2)];
      end else if (pick < 50) begin
        if (nest_depth != 0) r.text_byte = CloseCh[nest_stack[nest_depth-1]];
        else r.text_byte = CloseCh[$urandom_range(2)];
      end else if (pick < 58) begin
        r.text_byte = CloseCh[$urandom_range(2)];
      end else if (pick < 66) begin
        r.text_byte = ChQuote;
      end else if (pick < 72) begin
        r.text_byte = ChBslash;
      end else if (pick < 78) begin
        r.text_byte = ChNewline;
      end
      send_req(r);
      if (r.has_byte || r.doc_end) sent++;
    end
  endtask

  // nest past the stack depth, unwind a little, end the document
  task automatic nest_burst();
    send_req(byte_req(ChNewline, 1'b1));
    for (int i = 0; i < NestDepth + 3; i++) begin
      send_req(byte_req(OpenCh[$urandom_range(2)], 1'b0));
    end
    for (int i = 0; i < 5; i++) begin
      send_req(byte_req(CloseCh[$urandom_range(2)], 1'b0));
    end
    send_req(byte_req(8'($urandom_range(255)), 1'b1));
  endtask

  initial begin
    fails         = 0;
    src_idle_pct  = 6;
    sink_idle_pct = 73;
    clear_doc();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct  = 6;
          sink_idle_pct = 73;
        end
        1: begin
          src_idle_pct  = 73;
          sink_idle_pct = 6;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
      endcase
      if (phase == 0) begin
        for (int i = 0; i < NumDirected; i++) send_req(DirectedReqs[i]);
        drain();
      end
      random_text(28);
      nest_burst();
      random_text(28);
      drain();
    end
    repeat (8) @(posedge clk_i);
    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
